// ----- sv/sltc_pkg.sv -----
// ----------------------------------------------------------------------------
// sltc_pkg
// Types and constants shared by the shell line token classifier modules:
// lexer modes, segment classes, character codes and the segment record.
// ----------------------------------------------------------------------------
package sltc_pkg;

    typedef enum logic [3:0] {
        LEX_IDLE,
        LEX_COMMENT,
        LEX_OP_PIPE,
        LEX_OP_AMP,
        LEX_DIGIT,
        LEX_RED_A,
        LEX_RED_B,
        LEX_RED_D,
        LEX_SQ,
        LEX_DQ,
        LEX_VAR,
        LEX_VAR_NAME,
        LEX_VAR_BRACE,
        LEX_VAR_PFIRST,
        LEX_VAR_PAREN,
        LEX_WORD
    } lex_mode_t;

    localparam logic [3:0] CLS_COMMENT  = 4'd0;
    localparam logic [3:0] CLS_OPERATOR = 4'd1;
    localparam logic [3:0] CLS_REDIRECT = 4'd2;
    localparam logic [3:0] CLS_SQUOTE   = 4'd3;
    localparam logic [3:0] CLS_DQUOTE   = 4'd4;
    localparam logic [3:0] CLS_VARIABLE = 4'd5;
    localparam logic [3:0] CLS_GLOB     = 4'd6;
    localparam logic [3:0] CLS_ARGUMENT = 4'd7;
    localparam logic [3:0] CLS_COMMAND  = 4'd8;
    localparam logic [3:0] CLS_LINE_END = 4'd9;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_POUND  = 8'h23;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    // Result queue geometry: room for one byte's worst case of three segments.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int SEGS_MAX    = 3;

    typedef struct packed {
        logic [12:0] seg_start;
        logic [12:0] seg_end;
        logic [3:0]  seg_class;
        logic        final_res;
    } seg_t;

    typedef struct packed {
        logic [1:0]          count;
        seg_t [SEGS_MAX-1:0] seg;
    } step_out_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_redir(input logic [7:0] c);
        return (c == CH_GT) || (c == CH_LT);
    endfunction

    function automatic logic is_name(input logic [7:0] c);
        return is_digit(c) || (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)
            || (c == CH_UNDER);
    endfunction

    function automatic logic is_glob(input logic [7:0] c);
        return (c == CH_STAR) || (c == CH_QMARK) || (c == CH_LBRACK);
    endfunction

    function automatic logic ends_word(input logic [7:0] c);
        return is_space(c) || (c == CH_PIPE) || (c == CH_AMP) || (c == CH_SEMI)
            || is_redir(c) || (c == CH_SQUOTE) || (c == CH_DQUOTE)
            || (c == CH_DOLLAR) || (c == CH_POUND);
    endfunction

    function automatic seg_t make_seg(input logic [12:0] s, input logic [12:0] e,
                                      input logic [3:0] cls, input logic fin);
        seg_t r;
        r.seg_start = s;
        r.seg_end   = e;
        r.seg_class = cls;
        r.final_res = fin;
        return r;
    endfunction

endpackage

// ----- sv/sltc_lexer.sv -----
// ----------------------------------------------------------------------------
// sltc_lexer
// Lexer state and the combinational step logic: one accepted byte updates the
// state and yields up to three segments for the result queue.
// ----------------------------------------------------------------------------
module sltc_lexer #(
    parameter int LINE_MAX  = 4096,
    parameter int WORD_MAX  = 256,
    parameter int DEPTH_MAX = 255
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          ch,
    input  logic                last,
    output sltc_pkg::step_out_t step
);
    import sltc_pkg::*;

    localparam int PW  = $clog2(LINE_MAX + 1);
    localparam int WLW = $clog2(WORD_MAX + 1);
    localparam int CW  = (PW > WLW) ? PW : WLW;
    localparam int DW  = $clog2(DEPTH_MAX + 1);

    lex_mode_t         mode_reg, mode_next;
    logic [PW-1:0]     tb_reg, tb_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic              cmd_reg, cmd_next;
    logic [DW-1:0]     depth_reg, depth_next;
    logic              esc_reg, esc_next;
    logic              glob_reg, glob_next;

    logic [PW-1:0]     p;
    logic [PW-1:0]     close_end;
    logic              handled;
    logic              do_close;
    logic              restart;
    logic [1:0]        n;
    logic [4:0]        cinfo;

    function automatic logic [12:0] to13(input logic [PW-1:0] v);
        logic [PW+12:0] w;
        w = {13'd0, v};
        return w[12:0];
    endfunction

    // Returns {command position after the close, segment class}.
    function automatic logic [4:0] close_info(input lex_mode_t m, input logic [PW-1:0] e,
                                              input logic [PW-1:0] b, input logic cmd,
                                              input logic glob);
        logic [PW-1:0] len;
        logic [4:0]    r;
        len = e - b;
        case (m)
            LEX_COMMENT:   r = {cmd, CLS_COMMENT};
            LEX_OP_PIPE,
            LEX_OP_AMP:    r = {1'b1, CLS_OPERATOR};
            LEX_RED_A,
            LEX_RED_B,
            LEX_RED_D:     r = {cmd, CLS_REDIRECT};
            LEX_SQ:        r = {1'b0, CLS_SQUOTE};
            LEX_DQ:        r = {1'b0, CLS_DQUOTE};
            LEX_VAR,
            LEX_VAR_NAME,
            LEX_VAR_BRACE,
            LEX_VAR_PFIRST,
            LEX_VAR_PAREN: r = {1'b0, CLS_VARIABLE};
            default:
            begin
                if (CW'(len) < CW'(WORD_MAX))
                begin
                    if (cmd)
                        r = {1'b0, CLS_COMMAND};
                    else
                        r = {1'b0, glob ? CLS_GLOB : CLS_ARGUMENT};
                end
                else
                begin
                    r = {1'b0, CLS_ARGUMENT};
                end
            end
        endcase
        return r;
    endfunction

    always_comb
    begin
        mode_next  = mode_reg;
        tb_next    = tb_reg;
        pos_next   = pos_reg;
        cmd_next   = cmd_reg;
        depth_next = depth_reg;
        esc_next   = esc_reg;
        glob_next  = glob_reg;
        p          = pos_reg;
        close_end  = pos_reg;
        handled    = 1'b0;
        do_close   = 1'b0;
        restart    = 1'b0;
        n          = 2'd0;
        cinfo      = '0;
        step       = '0;

        if (pos_reg < PW'(LINE_MAX))
        begin
            // A digit that is not followed by a redirect becomes an ordinary word,
            // and the first byte after $( decides between $( and $((.
            if (mode_next == LEX_DIGIT)
            begin
                if (is_redir(ch))
                begin
                    mode_next = LEX_RED_A;
                    handled   = 1'b1;
                end
                else
                begin
                    mode_next = LEX_WORD;
                end
            end
            if (mode_next == LEX_VAR_PFIRST)
            begin
                mode_next = LEX_VAR_PAREN;
                if (ch == CH_LPAREN)
                begin
                    depth_next = DW'(2);
                    handled    = 1'b1;
                end
            end

            if (!handled)
            begin
                case (mode_next)
                    LEX_IDLE:
                        restart = 1'b1;
                    LEX_COMMENT:
                        if (ch == CH_NL)
                        begin
                            do_close = 1'b1;
                            restart  = 1'b1;
                        end
                    LEX_OP_PIPE,
                    LEX_OP_AMP:
                    begin
                        do_close = 1'b1;
                        if (ch == ((mode_next == LEX_OP_PIPE) ? CH_PIPE : CH_AMP))
                            close_end = p + PW'(1);
                        else
                            restart = 1'b1;
                    end
                    LEX_RED_A:
                        if (is_redir(ch))
                            mode_next = LEX_RED_B;
                        else if (ch == CH_AMP)
                            mode_next = LEX_RED_D;
                        else
                        begin
                            do_close = 1'b1;
                            restart  = 1'b1;
                        end
                    LEX_RED_B:
                        if (ch == CH_AMP)
                            mode_next = LEX_RED_D;
                        else
                        begin
                            do_close = 1'b1;
                            restart  = 1'b1;
                        end
                    LEX_RED_D:
                        if (!is_digit(ch))
                        begin
                            do_close = 1'b1;
                            restart  = 1'b1;
                        end
                    LEX_SQ:
                        if (ch == CH_SQUOTE)
                        begin
                            do_close  = 1'b1;
                            close_end = p + PW'(1);
                        end
                    LEX_DQ:
                        if (esc_next)
                            esc_next = 1'b0;
                        else if (ch == CH_BSLASH)
                            esc_next = 1'b1;
                        else if (ch == CH_DQUOTE)
                        begin
                            do_close  = 1'b1;
                            close_end = p + PW'(1);
                        end
                    LEX_VAR:
                        if (ch == CH_LBRACE)
                        begin
                            mode_next  = LEX_VAR_BRACE;
                            depth_next = DW'(1);
                        end
                        else if (ch == CH_LPAREN)
                        begin
                            mode_next  = LEX_VAR_PFIRST;
                            depth_next = DW'(1);
                        end
                        else if (ch == CH_QMARK || ch == CH_DOLLAR || ch == CH_BANG
                                 || ch == CH_POUND || ch == CH_AT || ch == CH_STAR
                                 || is_digit(ch))
                        begin
                            do_close  = 1'b1;
                            close_end = p + PW'(1);
                        end
                        else if (is_name(ch))
                            mode_next = LEX_VAR_NAME;
                        else
                        begin
                            do_close = 1'b1;
                            restart  = 1'b1;
                        end
                    LEX_VAR_NAME:
                        if (!is_name(ch))
                        begin
                            do_close = 1'b1;
                            restart  = 1'b1;
                        end
                    LEX_VAR_BRACE:
                        if (ch == CH_LBRACE)
                        begin
                            if (depth_next < DW'(DEPTH_MAX))
                                depth_next = depth_next + DW'(1);
                        end
                        else if (ch == CH_RBRACE)
                        begin
                            if (depth_next != '0)
                                depth_next = depth_next - DW'(1);
                            if (depth_next == '0)
                            begin
                                do_close  = 1'b1;
                                close_end = p + PW'(1);
                            end
                        end
                    LEX_VAR_PAREN:
                        if (esc_next)
                            esc_next = 1'b0;
                        else if (ch == CH_LPAREN)
                        begin
                            if (depth_next < DW'(DEPTH_MAX))
                                depth_next = depth_next + DW'(1);
                        end
                        else if (ch == CH_RPAREN)
                        begin
                            if (depth_next != '0)
                                depth_next = depth_next - DW'(1);
                            if (depth_next == '0)
                            begin
                                do_close  = 1'b1;
                                close_end = p + PW'(1);
                            end
                        end
                        else if (ch == CH_BSLASH)
                            esc_next = 1'b1;
                    default:
                        // Plain word; an escaped glob character still marks it as glob.
                        if (esc_next)
                        begin
                            esc_next = 1'b0;
                            if (is_glob(ch))
                                glob_next = 1'b1;
                        end
                        else if (ends_word(ch))
                        begin
                            do_close = 1'b1;
                            restart  = 1'b1;
                        end
                        else
                        begin
                            if (ch == CH_BSLASH)
                                esc_next = 1'b1;
                            if (is_glob(ch))
                                glob_next = 1'b1;
                        end
                endcase
            end

            if (do_close)
            begin
                cinfo = close_info(mode_next, close_end, tb_next, cmd_next, glob_next);
                step.seg[n] = make_seg(to13(tb_next), to13(close_end), cinfo[3:0], 1'b0);
                n = n + 2'd1;
                cmd_next   = cinfo[4];
                mode_next  = LEX_IDLE;
                depth_next = '0;
                esc_next   = 1'b0;
                glob_next  = 1'b0;
            end

            // The byte that closed a token (or arrived between tokens) may open the next.
            if (restart && !is_space(ch))
            begin
                tb_next    = p;
                esc_next   = 1'b0;
                glob_next  = 1'b0;
                depth_next = '0;
                if (ch == CH_POUND)
                    mode_next = LEX_COMMENT;
                else if (ch == CH_PIPE)
                    mode_next = LEX_OP_PIPE;
                else if (ch == CH_AMP)
                    mode_next = LEX_OP_AMP;
                else if (ch == CH_SEMI)
                begin
                    if (n != 2'd3)
                    begin
                        step.seg[n] = make_seg(to13(p), to13(p + PW'(1)), CLS_OPERATOR, 1'b0);
                        n = n + 2'd1;
                    end
                    cmd_next = 1'b1;
                end
                else if (is_redir(ch))
                    mode_next = LEX_RED_A;
                else if (is_digit(ch))
                    mode_next = LEX_DIGIT;
                else if (ch == CH_SQUOTE)
                    mode_next = LEX_SQ;
                else if (ch == CH_DQUOTE)
                    mode_next = LEX_DQ;
                else if (ch == CH_DOLLAR)
                    mode_next = LEX_VAR;
                else if (ch == CH_STAR || ch == CH_QMARK)
                begin
                    if (n != 2'd3)
                    begin
                        step.seg[n] = make_seg(to13(p), to13(p + PW'(1)), CLS_GLOB, 1'b0);
                        n = n + 2'd1;
                    end
                    cmd_next = 1'b0;
                end
                else
                begin
                    mode_next = LEX_WORD;
                    esc_next  = (ch == CH_BSLASH);
                    glob_next = is_glob(ch);
                end
            end

            pos_next = pos_reg + PW'(1);
        end

        if (last)
        begin
            if (mode_next != LEX_IDLE && n != 2'd3)
            begin
                cinfo = close_info(mode_next, pos_next, tb_next, cmd_next, glob_next);
                step.seg[n] = make_seg(to13(tb_next), to13(pos_next), cinfo[3:0], 1'b0);
                n = n + 2'd1;
            end
            if (n != 2'd3)
            begin
                step.seg[n] = make_seg(to13(pos_next), to13(pos_next), CLS_LINE_END, 1'b1);
                n = n + 2'd1;
            end
            mode_next  = LEX_IDLE;
            tb_next    = '0;
            pos_next   = '0;
            cmd_next   = 1'b1;
            depth_next = '0;
            esc_next   = 1'b0;
            glob_next  = 1'b0;
        end

        step.count = accept ? n : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= LEX_IDLE;
            tb_reg    <= '0;
            pos_reg   <= '0;
            cmd_reg   <= 1'b1;
            depth_reg <= '0;
            esc_reg   <= 1'b0;
            glob_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            tb_reg    <= tb_next;
            pos_reg   <= pos_next;
            cmd_reg   <= cmd_next;
            depth_reg <= depth_next;
            esc_reg   <= esc_next;
            glob_reg  <= glob_next;
        end
    end

endmodule

// ----- sv/sltc_seg_queue.sv -----
// ----------------------------------------------------------------------------
// sltc_seg_queue
// Four-entry segment queue: takes up to three segments per cycle from the
// lexer and hands them out one beat at a time.
// ----------------------------------------------------------------------------
module sltc_seg_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  sltc_pkg::step_out_t push,
    output logic                room,
    output logic                seg_valid,
    input  logic                seg_ready,
    output sltc_pkg::seg_t      head
);
    import sltc_pkg::*;

    seg_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                pop;

    assign pop       = seg_valid && seg_ready;
    assign seg_valid = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];
    // Room for the worst case of one byte, judged on the registered fill level.
    assign room      = (count_reg <= (QUEUE_AW + 1)'(QUEUE_DEPTH - SEGS_MAX));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QUEUE_AW'(push.count);
        rd_ptr_next = rd_ptr_reg + QUEUE_AW'(pop);
        count_next  = count_reg + (QUEUE_AW + 1)'(push.count) - (QUEUE_AW + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SEGS_MAX; i++)
        begin
            if (2'(i) < push.count)
                mem[wr_ptr_reg + QUEUE_AW'(i)] <= push.seg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- sv/shell_line_token_classifier.sv -----
// ----------------------------------------------------------------------------
// shell_line_token_classifier
// Cuts a shell command line, one byte per beat, into classified segments.
// ----------------------------------------------------------------------------
// The block takes one byte of a command line per cycle while byte_ready is
// high and returns a segment (start, end, class) for each token as it closes,
// plus a line-end segment after the byte marked last. Each accepted byte is
// lexed in the same cycle by the step logic and its zero to three segments
// are written into a four-entry result queue and handed out in order.
// Segments leave at one per cycle while seg_ready is high; byte_ready stays
// high while the queue holds at most one segment, so with a free output side
// the block sustains one byte per cycle, and bytes that yield several
// segments slow the input to the output's one-segment-per-cycle drain.
// ----------------------------------------------------------------------------
module shell_line_token_classifier #(
    parameter int LINE_MAX  = 4096,
    parameter int WORD_MAX  = 256,
    parameter int DEPTH_MAX = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  ch,
    input  logic        last,
    output logic        seg_valid,
    input  logic        seg_ready,
    output logic [12:0] seg_start,
    output logic [12:0] seg_end,
    output logic [3:0]  seg_class,
    output logic        final_res
);
    import sltc_pkg::*;

    step_out_t step;
    seg_t      head;
    logic      room;
    logic      accept;

    assign byte_ready = room;
    assign accept     = byte_valid && room;

    sltc_lexer #(
        .LINE_MAX  (LINE_MAX),
        .WORD_MAX  (WORD_MAX),
        .DEPTH_MAX (DEPTH_MAX)
    ) u_lexer (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .ch     (ch),
        .last   (last),
        .step   (step)
    );

    sltc_seg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .room      (room),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .head      (head)
    );

    assign seg_start = head.seg_start;
    assign seg_end   = head.seg_end;
    assign seg_class = head.seg_class;
    assign final_res = head.final_res;

endmodule
